/* rtl/gf2_incremental_dependency_finder_defines.svh */
// assertion macros for the gf2 dependency finder
`ifndef GF2_INCREMENTAL_DEPENDENCY_FINDER_DEFINES_SVH
`define GF2_INCREMENTAL_DEPENDENCY_FINDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GF2_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define GF2_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define GF2_ASSERT_IMP(label, clk, rst, a, c)
`define GF2_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

/* rtl/gf2idf_pkg.sv */
// ----------------------------------------------------------------------------
// gf2idf_pkg
// shared constants for the gf2 dependency finder
// ----------------------------------------------------------------------------
package gf2idf_pkg;
  localparam int RowsDefault = 64;
  localparam int ColsDefault = 64;
  localparam logic [1:0] ST_INDEP = 2'd0;
  localparam logic [1:0] ST_DEP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;
endpackage

/* rtl/gf2idf_ram.sv */
// ----------------------------------------------------------------------------
// gf2idf_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gf2idf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/gf2_incremental_dependency_finder.sv */
// ----------------------------------------------------------------------------
// gf2_incremental_dependency_finder
// incremental gaussian elimination over gf(2) with kernel vector output
//
//  channel | signals                                    | direction
//  in      | in_valid in_ready mode row_bits            | sink
//  out     | out_valid out_ready status row_index       | source
//          | pivot_column combination                   |
//
// an independent row goes through a reduce pass reading every slot, a pivot
// search of one column per cycle, a read-modify-write pass over the slot ram
// and one write of the new slot. a dependent row gives its result from the
// pivot search once the reduce pass leaves it zero. clear and full
// transactions give their result straight from idle. reset clears state,
// valid bits, counters and control flags, not the rams. input stalls while
// a result waits; the next item is taken the cycle after the result transaction.
// ----------------------------------------------------------------------------
module gf2_incremental_dependency_finder
  import gf2idf_pkg::*;
#(
  parameter int ROWS = RowsDefault,
  parameter int COLS = ColsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [63:0] row_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [6:0]  row_index,
  output logic [5:0]  pivot_column,
  output logic [63:0] combination
);
`include "gf2_incremental_dependency_finder_defines.svh"

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = 7;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_PIV  = 3'd2;
  localparam logic [2:0] S_ELIM = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]      state;
  logic [CW-1:0]   cnt;
  logic            rd_ok;
  logic [AW-1:0]   rd_slot;
  logic [CW-1:0]   rows_taken;
  logic [ROWS-1:0] valid;
  logic [COLS-1:0] r;
  logic [63:0]     comb;
  logic [AW-1:0]   idx;
  logic [5:0]      piv;
  logic [CW-1:0]   piv_cnt;
  logic            res_pend;
  logic [1:0]      res_st;
  logic [63:0]     res_comb;
  logic [5:0]      res_piv;
  logic [6:0]      res_idx;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [COLS-1:0] w_row, q_row;
  logic [63:0]     w_comb, q_comb;
  logic [5:0]      w_piv, q_piv;

  gf2idf_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_row (
    .clk, .we, .waddr, .wdata(w_row), .raddr, .rdata(q_row));
  gf2idf_ram #(.WIDTH(64), .DEPTH(ROWS)) u_comb (
    .clk, .we, .waddr, .wdata(w_comb), .raddr, .rdata(q_comb));
  gf2idf_ram #(.WIDTH(6), .DEPTH(ROWS)) u_piv (
    .clk, .we, .waddr, .wdata(w_piv), .raddr, .rdata(q_piv));

  assign in_ready  = (state == S_IDLE) && !res_pend;
  assign raddr     = cnt[AW-1:0];
  assign out_valid = res_pend;
  assign status       = res_st;
  assign row_index    = res_idx;
  assign pivot_column = res_piv;
  assign combination  = res_comb;

  logic [COLS-1:0] r_x;
  logic [63:0]     comb_x;
  logic            hit_red, hit_elim;
  logic [5:0]      q_piv_c;
  assign q_piv_c  = ({1'b0, q_piv} < 7'(COLS)) ? q_piv : 6'd0;
  assign hit_red  = rd_ok && valid[rd_slot] && r[q_piv_c];
  assign r_x      = hit_red ? (r ^ q_row) : r;
  assign comb_x   = hit_red ? (comb ^ q_comb) : comb;
  assign hit_elim = rd_ok && valid[rd_slot] && q_row[piv[$clog2(COLS)-1:0]];

  always_comb begin
    we = 1'b0;
    waddr = rd_slot;
    w_row = q_row ^ r;
    w_comb = q_comb ^ comb;
    w_piv = q_piv;
    if (state == S_ELIM && hit_elim) begin
      we = 1'b1;
    end else if (state == S_DONE) begin
      we = 1'b1;
      waddr = idx;
      w_row = r;
      w_comb = comb;
      w_piv = piv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rows_taken <= '0;
      valid      <= '0;
      res_pend   <= 1'b0;
      rd_ok      <= 1'b0;
      cnt        <= '0;
    end else begin
      if (res_pend && out_ready) begin
        res_pend <= 1'b0;
      end
      rd_slot <= cnt[AW-1:0];
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            res_piv  <= '0;
            res_comb <= '0;
            if (mode) begin
              res_pend   <= 1'b1;
              valid      <= '0;
              rows_taken <= '0;
              res_st     <= ST_CLEAR;
              res_idx    <= '0;
            end else if (rows_taken == CW'(ROWS)) begin
              res_pend <= 1'b1;
              res_st   <= ST_FULL;
              res_idx  <= 7'(ROWS);
            end else begin
              idx        <= rows_taken[AW-1:0];
              rows_taken <= rows_taken + 1'b1;
              r          <= row_bits[COLS-1:0];
              comb       <= 64'd1 << rows_taken[5:0];
              state      <= S_RED;
              cnt        <= CW'(1);
              rd_ok      <= 1'b1;
            end
          end else begin
            rd_ok <= 1'b0;
            cnt   <= '0;
          end
        end
        S_RED: begin
          r    <= r_x;
          comb <= comb_x;
          if (rd_ok && rd_slot == AW'(ROWS - 1)) begin
            rd_ok <= 1'b0;
            cnt   <= '0;
            state <= S_PIV;
            piv   <= '0;
            piv_cnt <= '0;
          end else begin
            cnt   <= (cnt == CW'(ROWS - 1)) ? cnt : cnt + 1'b1;
            rd_ok <= 1'b1;
          end
        end
        S_PIV: begin
          // lowest set column, one column per cycle
          if (r == '0) begin
            res_pend <= 1'b1;
            res_st   <= ST_DEP;
            res_idx  <= 7'(idx);
            res_piv  <= '0;
            res_comb <= comb;
            state    <= S_IDLE;
          end else if (r[piv_cnt[$clog2(COLS)-1:0]]) begin
            piv   <= 6'(piv_cnt);
            cnt   <= CW'(1);
            rd_ok <= 1'b1;
            state <= S_ELIM;
          end else begin
            piv_cnt <= piv_cnt + 1'b1;
          end
        end
        S_ELIM: begin
          if (rd_ok && rd_slot == AW'(ROWS - 1)) begin
            rd_ok <= 1'b0;
            state <= S_DONE;
          end else begin
            cnt   <= (cnt == CW'(ROWS - 1)) ? cnt : cnt + 1'b1;
            rd_ok <= 1'b1;
          end
        end
        S_DONE: begin
          valid[idx] <= 1'b1;
          res_pend <= 1'b1;
          res_st   <= ST_INDEP;
          res_idx  <= 7'(idx);
          res_piv  <= piv;
          res_comb <= comb;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GF2_ASSERT_IMP(a_no_take_busy, clk, rst, state != S_IDLE, !in_ready)
  `GF2_ASSERT_IMP(a_cnt_sat, clk, rst, 1'b1, rows_taken <= CW'(ROWS))
  `GF2_ASSERT_NXT(a_done_out, clk, rst, state == S_DONE, out_valid && status == ST_INDEP)
  `GF2_ASSERT_IMP(a_we_state, clk, rst, we, state == S_ELIM || state == S_DONE)
endmodule

/* dv/gf2_incremental_dependency_finder_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2_incremental_dependency_finder_checker
// watches both channels, keeps its own gf(2) basis and compares every result
// transaction field by field with the oldest expected one
// ----------------------------------------------------------------------------
module gf2_incremental_dependency_finder_checker
  import gf2idf_pkg::*;
#(
  parameter int ROWS = RowsDefault,
  parameter int COLS = ColsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        mode,
  input  logic [63:0] row_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [6:0]  row_index,
  input  logic [5:0]  pivot_column,
  input  logic [63:0] combination,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  st;
    logic [6:0]  idx;
    logic [5:0]  piv;
    logic [63:0] comb;
  } elim_result_t;

  elim_result_t result_q[$];
  logic [63:0]  span_row [64];
  logic [63:0]  span_comb[64];
  logic [5:0]   span_piv [64];
  logic [63:0]  span_used;
  logic [6:0]   taken;

  function automatic elim_result_t eliminate(input logic m, input logic [63:0] bits);
    elim_result_t res;
    logic [63:0] r, c, colmask;
    int unsigned p;
    colmask = (COLS == 64) ? '1 : ((64'd1 << COLS) - 1);
    res = '0;
    if (m) begin
      span_used = '0;
      taken = '0;
      res.st = ST_CLEAR;
      return res;
    end
    if (taken >= ROWS) begin
      res.st = ST_FULL;
      res.idx = 7'(ROWS);
      return res;
    end
    res.idx = taken;
    taken = taken + 7'd1;
    r = bits & colmask;
    c = 64'd1 << res.idx[5:0];
    for (int s = 0; s < 64; s++) begin
      if (span_used[s] && r[span_piv[s]]) begin
        r ^= span_row[s];
        c ^= span_comb[s];
      end
    end
    res.comb = c;
    if (r == '0) begin
      res.st = ST_DEP;
      return res;
    end
    p = 0;
    while (p < 63 && !r[p]) p++;
    for (int s = 0; s < 64; s++) begin
      if (span_used[s] && span_row[s][p]) begin
        span_row[s] ^= r;
        span_comb[s] ^= c;
      end
    end
    span_row[res.idx[5:0]] = r;
    span_comb[res.idx[5:0]] = c;
    span_piv[res.idx[5:0]] = 6'(p);
    span_used[res.idx[5:0]] = 1'b1;
    res.st = ST_INDEP;
    res.piv = 6'(p);
    return res;
  endfunction

  always @(posedge clk) begin
    elim_result_t exp_r;
    if (rst) begin
      span_used = '0;
      taken = '0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        result_q.insert(result_q.size(), eliminate(mode, row_bits));
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (status !== exp_r.st || row_index !== exp_r.idx ||
              pivot_column !== exp_r.piv || combination !== exp_r.comb) begin
            fail_count <= fail_count + 1;
            if (status !== exp_r.st)
              $error("status expected %0d got %0d", exp_r.st, status);
            if (row_index !== exp_r.idx)
              $error("row_index expected %0d got %0d", exp_r.idx, row_index);
            if (pivot_column !== exp_r.piv)
              $error("pivot_column expected %0d got %0d", exp_r.piv, pivot_column);
            if (combination !== exp_r.comb)
              $error("combination expected %h got %h", exp_r.comb, combination);
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

/* dv/gf2_incremental_dependency_finder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2_incremental_dependency_finder_tb
// drives row and clear transactions with random gaps and output stalls; low
// rank, sparse and random rows reach dependency, full and clear cases
// ----------------------------------------------------------------------------
module gf2_incremental_dependency_finder_tb;
  import gf2idf_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [63:0] row_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [6:0]  row_index;
  logic [5:0]  pivot_column;
  logic [63:0] combination;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] low_span[4];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gf2_incremental_dependency_finder u_top (.*);

  gf2_incremental_dependency_finder_checker u_checker (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_row(input logic m, input logic [63:0] bits);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    row_bits <= bits;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = 64'd1 << $urandom_range(63);
      2: v = low_span[$urandom_range(3)] ^
             (($urandom_range(1)) ? low_span[$urandom_range(3)] : '0);
      3: v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4: v = 64'hff << $urandom_range(56);
      default: v = 64'($urandom_range(15));
    endcase
    return v;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (low_span[i]) low_span[i] = {$urandom, $urandom};
    // directed: zero row, extremes, dependency, clear, full
    send_row(1'b0, '0);
    send_row(1'b0, '1);
    send_row(1'b0, 64'h8000_0000_0000_0000);
    send_row(1'b0, 64'h7fff_ffff_ffff_ffff);
    send_row(1'b0, 64'h0000_0000_0000_0001);
    send_row(1'b0, 64'haaaa_aaaa_aaaa_aaaa);
    send_row(1'b0, 64'h5555_5555_5555_5555);
    send_row(1'b1, '1);
    send_row(1'b0, 64'h3);
    send_row(1'b0, 64'h6);
    send_row(1'b0, 64'h5);
    send_row(1'b1, '0);
    for (int i = 0; i < 66; i++) send_row(1'b0, 64'd1 << (i % 64));
    send_row(1'b1, '0);
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 34 : 0;
      for (int i = 0; i < 560; i++) begin
        if ($urandom_range(99) < 3) send_row(1'b1, {$urandom, $urandom});
        else send_row(1'b0, rand_row());
        if (i == 280) wait_drained();
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
